[design/round_robin_scheduler_with_sleep_top_defines.svh]
// assertion macros for the round-robin scheduler
// used by the top level; needs nothing else
`ifndef ROUND_ROBIN_SCHEDULER_WITH_SLEEP_TOP_DEFINES_SVH
`define ROUND_ROBIN_SCHEDULER_WITH_SLEEP_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define RRS_CHECK_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define RRS_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/rrs_pkg.sv]
// shared constants, codes and types of the round-robin scheduler
// no dependencies
`default_nettype none

package rrs_pkg;

   // defaults of the top-level parameters
   localparam int MAX_TASKS_DEF   = 16;
   localparam int SLEEP_WIDTH_DEF = 16;

   // fixed field widths
   localparam int MODE_W   = 3;
   localparam int ID_W     = 4;
   localparam int TICKS_W  = 16;
   localparam int STATUS_W = 2;
   localparam int SLICE_W  = 16;

   // request modes
   localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SCHED  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ADD    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SLEEP  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RUN_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_IGNORED    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SLEEP_FULL = 2'd3;

   // per-task mode codes
   localparam logic [1:0] TM_IDLE     = 2'd0;
   localparam logic [1:0] TM_ACTIVE   = 2'd1;
   localparam logic [1:0] TM_SLEEPING = 2'd2;

   localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;
   localparam logic [TICKS_W-1:0] TICK_MAX    = 16'hFFFF;

   // queue control for one cycle
   typedef struct packed {
      logic pop;
      logic push;
   } qctl_type;

endpackage

`default_nettype wire

[design/rrs_intf.sv]
// channel interfaces of the round-robin scheduler: request, response, csr write
// depends on rrs_pkg
`default_nettype none

interface rrs_req_if;
   import rrs_pkg::*;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [ID_W-1:0]     task_id;
   logic [TICKS_W-1:0]  sleep_ticks;
   modport source (output valid, mode, task_id, sleep_ticks, input ready);
   modport sink   (input valid, mode, task_id, sleep_ticks, output ready);
endinterface

interface rrs_rsp_if;
   import rrs_pkg::*;
   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     active_task;
   logic                active_valid;
   logic [STATUS_W-1:0] status;
   modport source (output valid, active_task, active_valid, status, input ready);
   modport sink   (input valid, active_task, active_valid, status, output ready);
endinterface

interface rrs_csr_if;
   import rrs_pkg::*;
   logic               valid;
   logic               ready;
   logic [SLICE_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[design/round_robin_scheduler_with_sleep_top.sv]
// channel   | dir | payload                                   | beat when
// req       | in  | mode, task_id, sleep_ticks                | req.valid && req.ready
// rsp       | out | active_task, active_valid, status         | rsp.valid && rsp.ready
// csr       | in  | data (time slice)                         | csr.valid && csr.ready
//
// one request at a time: schedule, add and refused requests go through exec and done;
// a tick also walks the sleep queue, and remove and sleep also walk the run queue;
// the walks step one queue cell per cycle through the shifting cell rows
// the response sits in an output register; the next request is taken meanwhile
// synchronous active-high reset clears queues, task modes and sleep counts
// depends on rrs_pkg, rrs_intf, rrs_queue and the assertion header
`default_nettype none
`include "round_robin_scheduler_with_sleep_top_defines.svh"

module round_robin_scheduler_with_sleep_top #(
   parameter int MAX_TASKS   = rrs_pkg::MAX_TASKS_DEF,
   parameter int SLEEP_WIDTH = rrs_pkg::SLEEP_WIDTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   rrs_req_if.sink   req,
   rrs_rsp_if.source rsp,
   rrs_csr_if.sink   csr
);
   import rrs_pkg::*;

   localparam int TW  = $clog2(MAX_TASKS);
   localparam int CW  = $clog2(MAX_TASKS + 1);
   localparam int SW  = SLEEP_WIDTH;
   localparam int XW  = (TW > ID_W) ? TW : ID_W;
   localparam int TXW = (SW > TICKS_W) ? SW : TICKS_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_TICK   = 3'd2;
   localparam logic [2:0] S_REMOVE = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [TW-1:0]       id_ff, id_in;
   logic                id_ok_ff, id_ok_in;
   logic [SW-1:0]       ticks_ff, ticks_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CW-1:0]       walk_ff, walk_in;
   logic [SLICE_W-1:0]  slice_ff, slice_in;
   logic [TW-1:0]       cur_task_ff, cur_task_in;
   logic                cur_valid_ff, cur_valid_in;
   logic [TICKS_W-1:0]  cur_ticks_ff, cur_ticks_in;
   logic [TICKS_W-1:0]  idle_ticks_ff, idle_ticks_in;
   logic [1:0]          task_mode_ff [MAX_TASKS];
   logic [1:0]          task_mode_in [MAX_TASKS];
   logic [SW-1:0]       sleep_left_ff [MAX_TASKS];
   logic [SW-1:0]       sleep_left_in [MAX_TASKS];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_task_ff, rsp_task_in;
   logic                rsp_act_ff, rsp_act_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   qctl_type      run_ctl, sleep_ctl;
   logic [TW-1:0] run_data, sleep_data, run_head, sleep_head;
   logic [CW-1:0] run_cnt, sleep_cnt;
   logic [TW-1:0] tm_addr;
   logic [1:0]    tm_rd;
   logic [SW-1:0] sl_rd;
   logic          req_fire;
   logic [XW-1:0] id_x, cur_x;
   logic [TXW-1:0] tk_x;

   assign req_fire  = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;

   // run queue and sleep queue
   rrs_queue #(.DEPTH(MAX_TASKS), .DW(TW)) u_run_q (
      .clock     (clock),
      .reset     (reset),
      .ctl       (run_ctl),
      .push_data (run_data),
      .head      (run_head),
      .count     (run_cnt)
   );

   rrs_queue #(.DEPTH(MAX_TASKS), .DW(TW)) u_sleep_q (
      .clock     (clock),
      .reset     (reset),
      .ctl       (sleep_ctl),
      .push_data (sleep_data),
      .head      (sleep_head),
      .count     (sleep_cnt)
   );

   // single read address into each per-task table
   assign tm_addr = ((state_ff == S_EXEC) && (mode_ff == MODE_SCHED)) ? cur_task_ff : id_ff;
   assign tm_rd   = task_mode_ff[tm_addr];
   assign sl_rd   = sleep_left_ff[sleep_head];

   // request fields widened and clamped
   always_comb begin
      id_x = XW'(req.task_id);
      tk_x = TXW'(req.sleep_ticks);
      if (tk_x == '0) begin
         tk_x = TXW'(1);
      end
      if (tk_x > TXW'({SW{1'b1}})) begin
         tk_x = TXW'({SW{1'b1}});
      end
   end

   assign cur_x = XW'(cur_task_ff);

   // sequencer and scheduler state update
   always_comb begin : main_comb
      logic          valid_tmp;
      logic          preempt;
      logic [TW-1:0] nxt;
      logic [TICKS_W-1:0] used;

      valid_tmp     = 1'b0;
      preempt       = 1'b0;
      nxt           = cur_task_ff;
      used          = cur_ticks_ff;
      state_in      = state_ff;
      mode_in       = mode_ff;
      id_in         = id_ff;
      id_ok_in      = id_ok_ff;
      ticks_in      = ticks_ff;
      status_in     = status_ff;
      walk_in       = walk_ff;
      slice_in      = slice_ff;
      cur_task_in   = cur_task_ff;
      cur_valid_in  = cur_valid_ff;
      cur_ticks_in  = cur_ticks_ff;
      idle_ticks_in = idle_ticks_ff;
      task_mode_in  = task_mode_ff;
      sleep_left_in = sleep_left_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_act_in    = rsp_act_ff;
      rsp_status_in = rsp_status_ff;
      run_ctl       = '0;
      sleep_ctl     = '0;
      run_data      = id_ff;
      sleep_data    = id_ff;

      if (csr.valid) begin
         slice_in = csr.data;
      end
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in   = req.mode;
               id_in     = id_x[TW-1:0];
               id_ok_in  = (32'(req.task_id) < 32'(MAX_TASKS));
               ticks_in  = tk_x[SW-1:0];
               status_in = ST_OK;
               state_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_DONE;
            unique case (mode_ff)
               MODE_TICK: begin
                  // charge the running task
                  if (cur_valid_ff) begin
                     if (cur_task_ff == '0) begin
                        if (idle_ticks_ff != TICK_MAX) begin
                           idle_ticks_in = idle_ticks_ff + TICKS_W'(1);
                        end
                     end else if (cur_ticks_ff != TICK_MAX) begin
                        cur_ticks_in = cur_ticks_ff + TICKS_W'(1);
                     end
                  end
                  walk_in = sleep_cnt;
                  if (sleep_cnt != '0) begin
                     state_in = S_TICK;
                  end
               end

               MODE_SCHED: begin
                  valid_tmp = cur_valid_ff && (tm_rd == TM_ACTIVE);
                  if (valid_tmp) begin
                     used = (cur_task_ff == '0) ? idle_ticks_ff : cur_ticks_ff;
                     if (used >= slice_ff) begin
                        if (cur_task_ff == '0) begin
                           idle_ticks_in   = '0;
                           task_mode_in[0] = TM_IDLE;
                        end else begin
                           cur_ticks_in = '0;
                           preempt      = 1'b1;
                           task_mode_in[cur_task_ff] = TM_IDLE;
                        end
                        valid_tmp = 1'b0;
                     end
                  end
                  // pick the next task, requeueing a preempted one at the tail
                  if (!valid_tmp) begin
                     if (preempt) begin
                        if (run_cnt == '0) begin
                           nxt = cur_task_ff;
                        end else begin
                           nxt          = run_head;
                           run_ctl.pop  = 1'b1;
                           run_ctl.push = 1'b1;
                           run_data     = cur_task_ff;
                        end
                     end else if (run_cnt != '0) begin
                        nxt         = run_head;
                        run_ctl.pop = 1'b1;
                     end else begin
                        nxt = '0;
                     end
                     cur_task_in       = nxt;
                     task_mode_in[nxt] = TM_ACTIVE;
                     if (nxt != '0) begin
                        cur_ticks_in = '0;
                     end
                  end
                  cur_valid_in = 1'b1;
               end

               MODE_ADD: begin
                  if (!id_ok_ff || (id_ff == '0)) begin
                     status_in = ST_IGNORED;
                  end else if (run_cnt >= CW'(MAX_TASKS)) begin
                     status_in = ST_RUN_FULL;
                  end else begin
                     run_ctl.push        = 1'b1;
                     task_mode_in[id_ff] = TM_IDLE;
                     if (cur_task_ff == id_ff) begin
                        cur_ticks_in = '0;
                     end
                  end
               end

               MODE_REMOVE: begin
                  if (!id_ok_ff) begin
                     status_in = ST_IGNORED;
                  end else begin
                     if (cur_valid_ff && (cur_task_ff == id_ff)) begin
                        cur_valid_in = 1'b0;
                     end
                     walk_in = run_cnt;
                     if (run_cnt != '0) begin
                        state_in = S_REMOVE;
                     end
                  end
               end

               MODE_SLEEP: begin
                  if (!id_ok_ff) begin
                     status_in = ST_IGNORED;
                  end else if (tm_rd == TM_SLEEPING) begin
                     sleep_left_in[id_ff] = ticks_ff;
                  end else if (sleep_cnt >= CW'(MAX_TASKS)) begin
                     status_in = ST_SLEEP_FULL;
                  end else begin
                     sleep_left_in[id_ff] = ticks_ff;
                     task_mode_in[id_ff]  = TM_SLEEPING;
                     sleep_ctl.push       = 1'b1;
                     if (cur_valid_ff && (cur_task_ff == id_ff)) begin
                        cur_valid_in = 1'b0;
                     end
                     walk_in = run_cnt;
                     if (run_cnt != '0) begin
                        state_in = S_REMOVE;
                     end
                  end
               end

               default: begin
                  status_in = ST_IGNORED;
               end
            endcase
         end

         S_TICK: begin
            // one sleeper per cycle: count down, wake or retry
            walk_in    = walk_ff - CW'(1);
            sleep_data = sleep_head;
            run_data   = sleep_head;
            if (walk_ff == CW'(1)) begin
               state_in = S_DONE;
            end
            sleep_ctl.pop = 1'b1;
            if (sl_rd <= SW'(1)) begin
               if (sleep_head == '0) begin
                  sleep_left_in[sleep_head] = '0;
               end else if (run_cnt < CW'(MAX_TASKS)) begin
                  run_ctl.push                = 1'b1;
                  task_mode_in[sleep_head]    = TM_IDLE;
                  sleep_left_in[sleep_head]   = '0;
                  if (cur_task_ff == sleep_head) begin
                     cur_ticks_in = '0;
                  end
               end else begin
                  sleep_left_in[sleep_head] = SW'(1);
                  status_in      = ST_RUN_FULL;
                  sleep_ctl.push = 1'b1;
               end
            end else begin
               sleep_left_in[sleep_head] = sl_rd - SW'(1);
               sleep_ctl.push            = 1'b1;
            end
         end

         S_REMOVE: begin
            // rotate the run queue once, dropping the named task
            walk_in      = walk_ff - CW'(1);
            run_ctl.pop  = 1'b1;
            run_ctl.push = (run_head != id_ff);
            run_data     = run_head;
            if (walk_ff == CW'(1)) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_task_in   = cur_valid_ff ? cur_x[ID_W-1:0] : '0;
               rsp_act_in    = cur_valid_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         walk_ff       <= '0;
         slice_ff      <= SLICE_RESET;
         cur_task_ff   <= '0;
         cur_valid_ff  <= 1'b0;
         cur_ticks_ff  <= '0;
         idle_ticks_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < MAX_TASKS; k++) begin
            task_mode_ff[k]  <= TM_IDLE;
            sleep_left_ff[k] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         walk_ff       <= walk_in;
         slice_ff      <= slice_in;
         cur_task_ff   <= cur_task_in;
         cur_valid_ff  <= cur_valid_in;
         cur_ticks_ff  <= cur_ticks_in;
         idle_ticks_ff <= idle_ticks_in;
         rsp_valid_ff  <= rsp_valid_in;
         task_mode_ff  <= task_mode_in;
         sleep_left_ff <= sleep_left_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      id_ff         <= id_in;
      id_ok_ff      <= id_ok_in;
      ticks_ff      <= ticks_in;
      status_ff     <= status_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_act_ff    <= rsp_act_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.active_task  = rsp_task_ff;
   assign rsp.active_valid = rsp_act_ff;
   assign rsp.status       = rsp_status_ff;

   // checks
   `RRS_CHECK_NEXT(a_one_in_flight, clock, reset, req.valid && req.ready, !req.ready, "second beat taken while busy")
   `RRS_CHECK_NOW(a_walk_live, clock, reset, (state_ff == S_TICK) || (state_ff == S_REMOVE), walk_ff != '0, "queue walk with zero count")
   `RRS_CHECK_NOW(a_run_bound, clock, reset, 1'b1, (run_cnt <= CW'(MAX_TASKS)) && (sleep_cnt <= CW'(MAX_TASKS)), "queue count beyond depth")
   `RRS_CHECK_NOW(a_idle_task_zero, clock, reset, rsp.valid && !rsp.active_valid, rsp.active_task == '0, "task shown with none running")

endmodule

`default_nettype wire

[design/rrs_cell.sv]
// one queue cell: holds an entry, takes its right neighbour on shift
// no dependencies
`default_nettype none

module rrs_cell #(
   parameter int DW = 4
) (
   input  wire logic          clock,
   input  wire logic          shift,
   input  wire logic          load,
   input  wire logic [DW-1:0] right_data,
   input  wire logic [DW-1:0] load_data,
   output logic      [DW-1:0] data
);

   logic [DW-1:0] data_ff, data_in;

   // shift from the neighbour, a load of a new tail entry wins
   always_comb begin
      data_in = data_ff;
      if (shift) begin
         data_in = right_data;
      end
      if (load) begin
         data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

[design/rrs_queue.sv]
// fifo built as a row of shifting cells, head in cell 0
// depends on rrs_pkg and rrs_cell
`default_nettype none

module rrs_queue #(
   parameter  int DEPTH = 16,
   parameter  int DW    = 4,
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rrs_pkg::qctl_type ctl,
   input  wire logic [DW-1:0]     push_data,
   output logic      [DW-1:0]     head,
   output logic      [CW-1:0]     count
);
   import rrs_pkg::*;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] wpos;
   logic [DW-1:0] cell_q     [DEPTH];
   logic [DW-1:0] cell_right [DEPTH];

   // tail slot moves down by one when the head leaves in the same cycle
   assign wpos     = ctl.pop ? (count_ff - CW'(1)) : count_ff;
   assign count_in = count_ff + CW'(ctl.push) - CW'(ctl.pop);

   // row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_last
         assign cell_right[i] = '0;
      end else begin : g_mid
         assign cell_right[i] = cell_q[i+1];
      end
      rrs_cell #(.DW(DW)) u_cell (
         .clock      (clock),
         .shift      (ctl.pop),
         .load       (ctl.push && (wpos == CW'(i))),
         .right_data (cell_right[i]),
         .load_data  (push_data),
         .data       (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head  = cell_q[0];
   assign count = count_ff;

endmodule

`default_nettype wire
